>>> hw/rtl/sha256_pkg.sv
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUTPUT
  } state_t;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [3:0]  LEN_HI_SLOT = 4'd14;
  localparam logic [3:0]  LAST_SLOT = 4'd15;
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [2:0]  LAST_INDEX = 3'd7;
  localparam logic [2:0]  FULL_BYTES = 3'd4;

  function automatic logic [31:0] initial_hash(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] v;
    unique case (idx)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

>>> hw/rtl/sha256_hash_engine.sv
// channel   signals                                         direction
// msg       msg_valid msg_ready msg_word byte_count final_word   in
// digest    digest_valid digest_ready digest_word word_index
//           last_digest_word                                   out
//
// every sixteenth word starts a compression: rounds on the single round
// unit, then a chain update
// a final word adds padding words and one or two compressions,
// then eight digest transactions, one per cycle while digest_ready is high
// msg_ready is low during each compression and from a final word until
// the digest is drained
// rst is synchronous; the engine comes up ready for a new message
module sha256_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_ready,
  input  logic [31:0] msg_word,
  input  logic [2:0]  byte_count,
  input  logic        final_word,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_digest_word
);
  import sha256_pkg::*;

  state_t      state;
  state_t      state_next;
  logic [31:0] chain [8];
  logic [31:0] wv [8];
  logic [31:0] sched [16];
  logic [63:0] bit_length;
  logic [3:0]  fill;
  logic [5:0]  round_cnt;
  logic [2:0]  out_idx;
  logic        fin_active;
  logic        pend_pad;
  logic        len_hi_done;
  logic        len_done;

  logic        msg_acc;
  logic        out_acc;
  logic        push_en;
  logic [31:0] push_data;
  logic        wrap;
  logic [2:0]  cnt;
  logic [31:0] fin_data;
  logic [31:0] sched_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch_v;
  logic [31:0] maj_v;

  assign msg_acc = msg_valid && msg_ready;
  assign out_acc = digest_valid && digest_ready;
  assign wrap = push_en && (fill == LAST_SLOT);
  assign cnt = (byte_count > FULL_BYTES) ? FULL_BYTES : byte_count;

  // clear bytes past the count and place the pad byte after a short count
  always_comb begin
    case (cnt)
      3'd0:    fin_data = PAD_WORD;
      3'd1:    fin_data = {msg_word[31:24], 24'h80_0000};
      3'd2:    fin_data = {msg_word[31:16], 16'h8000};
      3'd3:    fin_data = {msg_word[31:8], 8'h80};
      default: fin_data = msg_word;
    endcase
  end

  // round unit
  assign ch_v = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign maj_v = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t1 = wv[7] + big_sigma1(wv[4]) + ch_v + round_k(round_cnt) + sched[0];
  assign t2 = big_sigma0(wv[0]) + maj_v;
  assign sched_new = small_sigma1(sched[14]) + sched[9] + small_sigma0(sched[1]) + sched[0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (msg_acc && fill == LAST_SLOT) begin
          state_next = ST_ROUND;
        end else if (msg_acc && final_word) begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (fill == LAST_SLOT) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_cnt == LAST_ROUND) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!fin_active) begin
          state_next = ST_IDLE;
        end else if (len_done) begin
          state_next = ST_OUTPUT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_OUTPUT: begin
        if (out_acc && out_idx == LAST_INDEX) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    msg_ready = 1'b0;
    digest_valid = 1'b0;
    push_en = 1'b0;
    push_data = 32'h0;
    unique case (state)
      ST_IDLE: begin
        msg_ready = 1'b1;
        push_en = msg_acc;
        push_data = final_word ? fin_data : msg_word;
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (pend_pad) begin
          push_data = PAD_WORD;
        end else if (fill == LEN_HI_SLOT) begin
          push_data = bit_length[63:32];
        end else if (fill == LAST_SLOT && len_hi_done) begin
          push_data = bit_length[31:0];
        end
      end
      ST_OUTPUT: begin
        digest_valid = 1'b1;
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  assign digest_word = chain[out_idx];
  assign word_index = out_idx;
  assign last_digest_word = (out_idx == LAST_INDEX);

  // message schedule window, also the block buffer while collecting
  always_ff @(posedge clk) begin
    if (push_en || state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[15] <= push_en ? push_data : sched_new;
    end
  end

  always_ff @(posedge clk) begin
    if (wrap) begin
      for (int i = 0; i < 8; i++) begin
        wv[i] <= chain[i];
      end
    end else if (state == ST_ROUND) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= initial_hash(3'(i));
      end
      bit_length <= 64'h0;
      fill <= 4'h0;
      round_cnt <= 6'h0;
      out_idx <= 3'h0;
      fin_active <= 1'b0;
      pend_pad <= 1'b0;
      len_hi_done <= 1'b0;
      len_done <= 1'b0;
    end else begin
      state <= state_next;
      if (push_en) begin
        fill <= fill + 4'd1;
      end
      if (wrap) begin
        round_cnt <= 6'h0;
      end else if (state == ST_ROUND) begin
        round_cnt <= round_cnt + 6'd1;
      end
      if (state == ST_IDLE && msg_acc) begin
        if (final_word) begin
          bit_length <= bit_length + {58'h0, cnt, 3'b000};
          fin_active <= 1'b1;
          pend_pad <= (cnt == FULL_BYTES);
        end else begin
          bit_length <= bit_length + 64'd32;
        end
      end
      if (state == ST_PAD) begin
        pend_pad <= 1'b0;
        if (!pend_pad && fill == LEN_HI_SLOT) begin
          len_hi_done <= 1'b1;
        end
        if (!pend_pad && fill == LAST_SLOT && len_hi_done) begin
          len_done <= 1'b1;
        end
      end
      if (state == ST_UPDATE) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + wv[i];
        end
      end
      if (out_acc) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == LAST_INDEX) begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= initial_hash(3'(i));
          end
          bit_length <= 64'h0;
          fill <= 4'h0;
          fin_active <= 1'b0;
          pend_pad <= 1'b0;
          len_hi_done <= 1'b0;
          len_done <= 1'b0;
        end
      end
    end
  end

endmodule

>>> tb/sha256_digest_checker.sv
`timescale 1ns / 100ps

module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  input  logic        msg_ready,
  input  logic [31:0] msg_word,
  input  logic [2:0]  byte_count,
  input  logic        final_word,
  input  logic        digest_valid,
  input  logic        digest_ready,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_digest_word,
  output int          words_due,
  output int          error_count
);

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] PAD_MARK = 32'h0000_0080;
  localparam logic [2:0]  WORD_BYTES = 3'd4;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  digest_beat_t expected_digest [$];

  logic [31:0] chain_h [8];
  logic [31:0] blk_buf [16];
  logic [63:0] msg_bits;
  logic [3:0]  fill_pos;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain_h[i] = IV_TAB[i];
    msg_bits = '0;
    fill_pos = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk_buf[i];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + K_TAB[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endtask

  task automatic push_block_word(input logic [31:0] w);
    blk_buf[fill_pos] = w;
    fill_pos = fill_pos + 4'd1;
    if (fill_pos == 4'd0) compress_block();
  endtask

  task automatic sha_absorb_word(input logic [31:0] w, input logic [2:0] cnt_in,
                                 input logic fin);
    int cnt;
    logic [31:0] keep;
    digest_beat_t beat;
    cnt = (cnt_in > WORD_BYTES) ? 4 : int'(cnt_in);
    if (!fin) begin
      msg_bits += 64'd32;
      push_block_word(w);
      return;
    end
    msg_bits += 64'(8 * cnt);
    if (cnt == 4) begin
      push_block_word(w);
      push_block_word(PAD_MARK << 24);
    end else begin
      keep = (cnt == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * cnt));
      push_block_word((w & keep) | (PAD_MARK << (24 - 8 * cnt)));
    end
    // no room left for the length: close this block first
    if (fill_pos == 4'd15) push_block_word(32'h0);
    while (fill_pos < 4'd14) push_block_word(32'h0);
    push_block_word(msg_bits[63:32]);
    push_block_word(msg_bits[31:0]);
    for (int i = 0; i < 8; i++) begin
      beat.word = chain_h[i];
      beat.idx  = 3'(i);
      beat.last = (i == 7);
      expected_digest.push_back(beat);
    end
    restart_message();
  endtask

  always @(posedge clk) begin : track
    digest_beat_t want;
    if (rst) begin
      restart_message();
      expected_digest.delete();
      error_count = 0;
    end else begin
      if (msg_valid && msg_ready) sha_absorb_word(msg_word, byte_count, final_word);
      if (digest_valid && digest_ready) begin
        if (expected_digest.size() == 0) begin
          $display("%0t: unexpected digest transaction, word %h index %0d last %b",
                   $time, digest_word, word_index, last_digest_word);
          error_count++;
        end else begin
          want = expected_digest.pop_front();
          if (digest_word !== want.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, want.word,
                     digest_word);
            error_count++;
          end
          if (word_index !== want.idx) begin
            $display("%0t: word_index expected %0d actual %0d", $time, want.idx,
                     word_index);
            error_count++;
          end
          if (last_digest_word !== want.last) begin
            $display("%0t: last_digest_word expected %b actual %b", $time, want.last,
                     last_digest_word);
            error_count++;
          end
        end
      end
    end
    words_due = expected_digest.size();
  end

endmodule

>>> tb/tb_sha256_hash_engine.sv
`timescale 1ns / 100ps

module tb_sha256_hash_engine;

  localparam int STALL_LIMIT = 2000;
  localparam int WORD_TARGET = 300;

  logic        clk;
  logic        rst;
  logic        msg_valid;
  logic        msg_ready;
  logic [31:0] msg_word;
  logic [2:0]  byte_count;
  logic        final_word;
  logic        digest_valid;
  logic        digest_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_digest_word;

  int words_due;
  int error_count;
  int idle_cycles;
  int words_sent;
  int rdy_hold;
  int rdy_calm;
  int rdy_pick;
  bit msg_burst;

  sha256_hash_engine dut (
    .clk(clk),
    .rst(rst),
    .msg_valid(msg_valid),
    .msg_ready(msg_ready),
    .msg_word(msg_word),
    .byte_count(byte_count),
    .final_word(final_word),
    .digest_valid(digest_valid),
    .digest_ready(digest_ready),
    .digest_word(digest_word),
    .word_index(word_index),
    .last_digest_word(last_digest_word)
  );

  sha256_digest_checker checker_i (
    .clk(clk),
    .rst(rst),
    .msg_valid(msg_valid),
    .msg_ready(msg_ready),
    .msg_word(msg_word),
    .byte_count(byte_count),
    .final_word(final_word),
    .digest_valid(digest_valid),
    .digest_ready(digest_ready),
    .digest_word(digest_word),
    .word_index(word_index),
    .last_digest_word(last_digest_word),
    .words_due(words_due),
    .error_count(error_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic fin);
    int gap;
    gap = (msg_burst || $urandom_range(0, 1)) ? 0 : pick_gap();
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_valid  <= 1'b1;
    msg_word   <= w;
    byte_count <= cnt;
    final_word <= fin;
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int body_words, input logic [2:0] last_cnt);
    logic [2:0] cnt;
    for (int i = 0; i < body_words; i++) begin
      cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word($urandom, cnt, 1'b0);
    end
    send_word($urandom, last_cnt, 1'b1);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    if (rdy_calm > 0) begin
      rdy_calm--;
      digest_ready <= 1'b1;
    end else if (rdy_hold > 0) begin
      rdy_hold--;
      digest_ready <= 1'b0;
    end else begin
      digest_ready <= 1'b1;
      rdy_pick = $urandom_range(0, 99);
      if (rdy_pick < 4) rdy_calm = $urandom_range(20, 120);
      else if (rdy_pick < 35) rdy_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_valid && msg_ready) || (digest_valid && digest_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int pick;
    int len;
    rst = 1'b1;
    msg_valid = 1'b0;
    msg_word = '0;
    byte_count = '0;
    final_word = 1'b0;
    digest_ready = 1'b0;
    idle_cycles = 0;
    words_sent = 0;
    rdy_hold = 0;
    rdy_calm = 0;
    msg_burst = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one-word messages for every count from empty up, stray bits past the count
    send_word(32'hffff_ffff, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'hffff_ffff, 3'd2, 1'b1);
    send_word(32'hffff_ffff, 3'd3, 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b1);
    send_word($urandom, 3'd5, 1'b1);
    send_word($urandom, 3'd6, 1'b1);
    send_word($urandom, 3'd7, 1'b1);
    // short counts on body words are ignored
    send_word(32'h0000_0000, 3'd0, 1'b0);
    send_word(32'hffff_ffff, 3'd2, 1'b0);
    send_word(32'ha5a5_5a5a, 3'd7, 1'b1);
    // padding spills into a second block
    msg_burst = 1'b1;
    send_message(14, 3'd2);

    while (words_sent < WORD_TARGET) begin
      msg_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 3) len = 16 * $urandom_range(0, 2) + $urandom_range(13, 15);
      else if (pick == 3) len = $urandom_range(30, 60);
      else len = $urandom_range(0, 12);
      send_message(len, 3'($urandom_range(0, 7)));
    end
    msg_valid <= 1'b0;

    while (words_due != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
